[hdl/deque_with_positional_insert_unit_defines.svh]
// Assertion macros shared by the deque checker.
`ifndef DEQUE_WITH_POSITIONAL_INSERT_UNIT_DEFINES_SVH
`define DEQUE_WITH_POSITIONAL_INSERT_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DQPI_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("deque check failed in the same cycle");

// Consequent must hold in the cycle after the antecedent.
`define DQPI_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("deque check failed in the following cycle");

`endif

[hdl/dqpi_pkg.sv]
`default_nettype none

package dqpi_pkg;

   localparam int unsigned CAPACITY_DEF = 16;

   localparam int unsigned DATA_W    = 32;
   localparam int unsigned COMMAND_W = 3;
   localparam int unsigned POSITION_W = 5;
   localparam int unsigned COUNT_W   = 5;
   localparam int unsigned STATUS_W  = 2;

   typedef logic [COMMAND_W-1:0]  command_type;
   typedef logic signed [DATA_W-1:0] data_type;
   typedef logic [POSITION_W-1:0] position_type;
   typedef logic [COUNT_W-1:0]    count_type;
   typedef logic [STATUS_W-1:0]   status_type;

   localparam command_type CMD_PUSH_FRONT = 3'd0;
   localparam command_type CMD_PUSH_BACK  = 3'd1;
   localparam command_type CMD_INSERT     = 3'd2;
   localparam command_type CMD_POP_FRONT  = 3'd3;
   localparam command_type CMD_POP_BACK   = 3'd4;
   localparam command_type CMD_ERASE      = 3'd5;
   localparam command_type CMD_CLEAR      = 3'd6;

   localparam status_type ST_OK     = 2'd0;
   localparam status_type ST_BADPOS = 2'd1;
   localparam status_type ST_EMPTY  = 2'd2;
   localparam status_type ST_FULL   = 2'd3;

   typedef logic [1:0] shift_kind_type;

   localparam shift_kind_type SHIFT_HOLD  = 2'd0;
   localparam shift_kind_type SHIFT_OPEN  = 2'd1;
   localparam shift_kind_type SHIFT_CLOSE = 2'd2;

   // Broadcast to every cell of the chain.
   typedef struct packed {
      shift_kind_type kind;
      data_type       value;
   } cell_ctrl_type;

endpackage

`default_nettype wire

[hdl/dqpi_if.sv]
`default_nettype none

interface dqpi_req_if;
   import dqpi_pkg::*;

   logic         valid;
   logic         ready;
   command_type  command;
   data_type     value;
   position_type position;

   modport source (output valid, output command, output value, output position,
                   input ready);
   modport sink   (input valid, input command, input value, input position,
                   output ready);
endinterface

interface dqpi_rsp_if;
   import dqpi_pkg::*;

   logic       valid;
   logic       ready;
   data_type   front_value;
   data_type   back_value;
   count_type  count;
   status_type status;

   modport source (output valid, output front_value, output back_value, output count,
                   output status, input ready);
   modport sink   (input valid, input front_value, input back_value, input count,
                   input status, output ready);
endinterface

`default_nettype wire

[hdl/deque_with_positional_insert_unit.sv]
`default_nettype none
// An accepted command beat goes through the middle stage, then the output register.
// One command per cycle while responses drain; every cell of the chain shifts in the
//   same cycle, so an insert or erase costs no more than a push or pop.
// Backpressure on the response side stalls the middle stage and then the request side.
// Reset (synchronous, active high) empties the queue and drops any beat in flight;
//   cell contents are not cleared and are never shown before being written.

module deque_with_positional_insert_unit #(
   parameter int unsigned CAPACITY = dqpi_pkg::CAPACITY_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   dqpi_req_if.sink   req_ch,
   dqpi_rsp_if.source rsp_ch
);
   import dqpi_pkg::*;

   localparam int unsigned OCC_W = $clog2(CAPACITY + 1);
   localparam int unsigned CNT_EXT_W = (OCC_W > COUNT_W) ? OCC_W : COUNT_W;

   // Queue length and handshake control.
   logic [OCC_W-1:0] occ_ff;
   logic [OCC_W-1:0] occ_in;
   logic             mid_valid_ff;
   status_type       mid_status_ff;
   status_type       status_in;
   logic             rsp_valid_ff;
   data_type         rsp_front_ff;
   data_type         rsp_back_ff;
   count_type        rsp_count_ff;
   status_type       rsp_status_ff;

   logic fire;
   logic mid_adv;

   cell_ctrl_type    ctrl;
   logic [OCC_W-1:0] at;

   data_type cell_data [CAPACITY];
   data_type cell_tap  [CAPACITY];
   data_type back_value;
   data_type front_value;
   logic [CNT_EXT_W-1:0] occ_ext;

   // Middle stage advances when the output register is free or being drained.
   assign mid_adv      = mid_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !mid_valid_ff || mid_adv;
   assign fire         = req_ch.valid && req_ch.ready;

   // Decode the command into one shift order for the whole chain.
   dqpi_ctrl #(
      .CAPACITY (CAPACITY),
      .OCC_W    (OCC_W)
   ) u_ctrl (
      .fire         (fire),
      .command      (req_ch.command),
      .value        (req_ch.value),
      .position     (req_ch.position),
      .occupancy    (occ_ff),
      .ctrl         (ctrl),
      .at           (at),
      .occupancy_in (occ_in),
      .status       (status_in)
   );

   // Row of cells, front at index 0; each takes from a neighbour on a shift.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      data_type prev_d;
      data_type next_d;

      if (i == 0) begin : g_first
         assign prev_d = cell_data[i];
      end else begin : g_mid_prev
         assign prev_d = cell_data[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign next_d = cell_data[i];
      end else begin : g_mid_next
         assign next_d = cell_data[i+1];
      end

      dqpi_cell #(
         .IDX   (i),
         .OCC_W (OCC_W)
      ) u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .at        (at),
         .occupancy (occ_ff),
         .prev_data (prev_d),
         .next_data (next_d),
         .data      (cell_data[i]),
         .tap       (cell_tap[i])
      );
   end

   // Only the tail cell drives a non-zero tap, so an OR gathers the back value.
   always_comb begin
      back_value = '0;
      for (int k = 0; k < CAPACITY; k++) begin
         back_value = back_value | cell_tap[k];
      end
   end

   assign front_value = (occ_ff == '0) ? '0 : cell_data[0];
   assign occ_ext     = CNT_EXT_W'(occ_ff);

   // Commit the command: length and status land with the cell shift.
   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= '0;
         mid_valid_ff <= 1'b0;
      end else begin
         if (fire) begin
            occ_ff <= occ_in;
         end
         if (fire) begin
            mid_valid_ff <= 1'b1;
         end else if (mid_adv) begin
            mid_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         mid_status_ff <= status_in;
      end
   end

   // Output register: sample the chain as the middle beat leaves.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (mid_adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (mid_adv) begin
         rsp_front_ff  <= front_value;
         rsp_back_ff   <= back_value;
         rsp_count_ff  <= occ_ext[COUNT_W-1:0];
         rsp_status_ff <= mid_status_ff;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.front_value = rsp_front_ff;
   assign rsp_ch.back_value  = rsp_back_ff;
   assign rsp_ch.count       = rsp_count_ff;
   assign rsp_ch.status      = rsp_status_ff;

endmodule

`default_nettype wire

[hdl/dqpi_cell.sv]
`default_nettype none

module dqpi_cell #(
   parameter int unsigned IDX   = 0,
   parameter int unsigned OCC_W = $clog2(dqpi_pkg::CAPACITY_DEF + 1)
) (
   input  wire logic                   clock,
   input  wire dqpi_pkg::cell_ctrl_type ctrl,
   input  wire logic [OCC_W-1:0]       at,
   input  wire logic [OCC_W-1:0]       occupancy,
   input  wire dqpi_pkg::data_type     prev_data,
   input  wire dqpi_pkg::data_type     next_data,
   output dqpi_pkg::data_type          data,
   output dqpi_pkg::data_type          tap
);
   import dqpi_pkg::*;

   localparam logic [OCC_W-1:0] MY_IDX   = OCC_W'(IDX);
   localparam logic [OCC_W-1:0] TAIL_OCC = OCC_W'(IDX + 1);

   data_type data_ff;
   data_type data_in;

   // Take from the front neighbour, the back neighbour, the new value, or hold.
   always_comb begin
      data_in = data_ff;
      case (ctrl.kind)
         SHIFT_OPEN: begin
            if (MY_IDX > at) begin
               data_in = prev_data;
            end else if (MY_IDX == at) begin
               data_in = ctrl.value;
            end
         end
         SHIFT_CLOSE: begin
            if (MY_IDX >= at) begin
               data_in = next_data;
            end
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;
   // Drive the tail tap only from the last occupied cell.
   assign tap  = (occupancy == TAIL_OCC) ? data_ff : '0;

endmodule

`default_nettype wire

[hdl/dqpi_ctrl.sv]
`default_nettype none

module dqpi_ctrl #(
   parameter int unsigned CAPACITY = dqpi_pkg::CAPACITY_DEF,
   parameter int unsigned OCC_W    = $clog2(CAPACITY + 1)
) (
   input  wire logic                     fire,
   input  wire dqpi_pkg::command_type    command,
   input  wire dqpi_pkg::data_type       value,
   input  wire dqpi_pkg::position_type   position,
   input  wire logic [OCC_W-1:0]         occupancy,
   output dqpi_pkg::cell_ctrl_type       ctrl,
   output logic [OCC_W-1:0]              at,
   output logic [OCC_W-1:0]              occupancy_in,
   output dqpi_pkg::status_type          status
);
   import dqpi_pkg::*;

   localparam int unsigned CMP_W = (OCC_W > POSITION_W) ? OCC_W : POSITION_W;
   localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(CAPACITY);
   localparam logic [OCC_W-1:0] OCC_ONE  = OCC_W'(1);

   logic [CMP_W-1:0] pos_ext;
   logic [CMP_W-1:0] occ_ext;
   logic             is_full;
   logic             is_empty;
   shift_kind_type   kind;

   assign pos_ext  = CMP_W'(position);
   assign occ_ext  = CMP_W'(occupancy);
   assign is_full  = (occupancy == OCC_FULL);
   assign is_empty = (occupancy == '0);

   always_comb begin
      kind         = SHIFT_HOLD;
      at           = '0;
      occupancy_in = occupancy;
      status       = ST_OK;
      unique case (command)
         CMD_PUSH_FRONT: begin
            if (is_full) begin
               status = ST_FULL;
            end else begin
               kind = SHIFT_OPEN;
               occupancy_in = occupancy + OCC_ONE;
            end
         end
         CMD_PUSH_BACK: begin
            if (is_full) begin
               status = ST_FULL;
            end else begin
               kind = SHIFT_OPEN;
               at = occupancy;
               occupancy_in = occupancy + OCC_ONE;
            end
         end
         CMD_INSERT: begin
            if (pos_ext > occ_ext) begin
               status = ST_BADPOS;
            end else if (is_full) begin
               status = ST_FULL;
            end else begin
               kind = SHIFT_OPEN;
               at = pos_ext[OCC_W-1:0];
               occupancy_in = occupancy + OCC_ONE;
            end
         end
         CMD_POP_FRONT: begin
            if (is_empty) begin
               status = ST_EMPTY;
            end else begin
               kind = SHIFT_CLOSE;
               occupancy_in = occupancy - OCC_ONE;
            end
         end
         CMD_POP_BACK: begin
            if (is_empty) begin
               status = ST_EMPTY;
            end else begin
               // Nothing beyond the back needs to move: just shorten.
               occupancy_in = occupancy - OCC_ONE;
            end
         end
         CMD_ERASE: begin
            if (pos_ext >= occ_ext) begin
               status = ST_BADPOS;
            end else begin
               kind = SHIFT_CLOSE;
               at = pos_ext[OCC_W-1:0];
               occupancy_in = occupancy - OCC_ONE;
            end
         end
         CMD_CLEAR: begin
            occupancy_in = '0;
         end
         default: begin
            status = ST_OK;
         end
      endcase
   end

   assign ctrl.kind  = fire ? kind : SHIFT_HOLD;
   assign ctrl.value = value;

endmodule

`default_nettype wire

[hdl/dqpi_checker.sv]
`default_nettype none
`include "deque_with_positional_insert_unit_defines.svh"

module dqpi_checker #(
   parameter int unsigned CAPACITY = dqpi_pkg::CAPACITY_DEF
) (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_ready,
   input wire dqpi_pkg::data_type   rsp_front_value,
   input wire dqpi_pkg::data_type   rsp_back_value,
   input wire dqpi_pkg::count_type  rsp_count,
   input wire dqpi_pkg::status_type rsp_status
);
   import dqpi_pkg::*;

   localparam logic COUNT_EXACT = (CAPACITY < 32);

   // A stalled response beat holds.
   `DQPI_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_front_value) && $stable(rsp_back_value) && $stable(rsp_count) && $stable(rsp_status))
   // A pop on empty leaves an empty queue.
   `DQPI_ASSERT_SAME(a_empty_pop, clock, reset, rsp_valid && rsp_status == ST_EMPTY, rsp_count == '0 && rsp_front_value == '0 && rsp_back_value == '0)
   // An empty queue reports zero at both ends.
   `DQPI_ASSERT_SAME(a_empty_zero, clock, reset, COUNT_EXACT && rsp_valid && rsp_count == '0, rsp_front_value == '0 && rsp_back_value == '0)
   // A single entry is both front and back.
   `DQPI_ASSERT_SAME(a_single_ends, clock, reset, COUNT_EXACT && rsp_valid && rsp_count == count_type'(1), rsp_front_value == rsp_back_value)

endmodule

bind deque_with_positional_insert_unit dqpi_checker #(
   .CAPACITY (CAPACITY)
) u_dqpi_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_front_value (rsp_ch.front_value),
   .rsp_back_value  (rsp_ch.back_value),
   .rsp_count       (rsp_ch.count),
   .rsp_status      (rsp_ch.status)
);

`default_nettype wire
